// ===== hdl/h4df_pkg.sv =====
`default_nettype none
package h4df_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned POS_W  = 17;
  localparam int unsigned KIND_W = 3;

  localparam logic [KIND_W-1:0] KIND_NONE    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_COMMAND = 3'd1;
  localparam logic [KIND_W-1:0] KIND_ACL     = 3'd2;
  localparam logic [KIND_W-1:0] KIND_SCO     = 3'd3;
  localparam logic [KIND_W-1:0] KIND_EVENT   = 3'd4;
  localparam logic [KIND_W-1:0] KIND_ISO     = 3'd5;

  localparam logic [POS_W-1:0] HDR_LEN_CMD_SCO = 17'd4;
  localparam logic [POS_W-1:0] HDR_LEN_ACL_ISO = 17'd5;
  localparam logic [POS_W-1:0] HDR_LEN_EVENT   = 17'd3;

  localparam logic [15:0] ISO_LEN_MASK = 16'h3fff;

  localparam logic [BYTE_W-1:0] EVT_CMD_COMPLETE = 8'h0e;
  localparam logic [15:0]       OPCODE_EXT_FEAT  = 16'h1004;
  localparam logic [BYTE_W-1:0] EXT_FEAT_PAGE    = 8'h02;
  localparam logic [BYTE_W-1:0] STATUS_OK        = 8'h00;

  localparam logic [POS_W-1:0] POS_TYPE      = 17'd0;
  localparam logic [POS_W-1:0] POS_EVT_CODE  = 17'd1;
  localparam logic [POS_W-1:0] POS_EVT_LEN   = 17'd2;
  localparam logic [POS_W-1:0] POS_LEN_LO    = 17'd3;
  localparam logic [POS_W-1:0] POS_LEN_HI    = 17'd4;
  localparam logic [POS_W-1:0] POS_OPCODE_HI = 17'd5;
  localparam logic [POS_W-1:0] POS_STATUS    = 17'd6;
  localparam logic [POS_W-1:0] POS_PAGE      = 17'd7;
  localparam logic [POS_W-1:0] POS_FEAT0     = 17'd9;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_PATCH_ENABLE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FEATURE_MASK = 1'd1;
  localparam logic [BYTE_W-1:0]    FEATURE_MASK_RST = 8'h04;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              forwarded;
    logic              packet_start;
    logic              packet_end;
    logic              was_patched;
  } result_t;

endpackage
`default_nettype wire

// ===== hdl/hci_h4_packet_deframer.sv =====
`default_nettype none
// channel  dir  handshake          payload
// in       in   in_valid/in_stall  in_byte
// out      out  out_valid/out_stall out_byte forwarded packet_start packet_end was_patched
// cfg      in   cfg_valid/cfg_ready cfg_index cfg_data
//
// One byte per cycle sustained while out_stall is low; an accepted byte waits in the
// input register, then is framed and loaded into the output register, raising out_valid.
// Framing state updates as a byte moves into the output register.
// rst is synchronous, clears both valid bits and the framing state, and resets config to its defaults.
// out_stall holds the output register and backs up into in_stall through the
// input register in the same cycle. cfg_ready is always high.
module hci_h4_packet_deframer (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [h4df_pkg::BYTE_W-1:0]     in_byte,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [h4df_pkg::BYTE_W-1:0]          out_byte,
  output logic                                 forwarded,
  output logic                                 packet_start,
  output logic                                 packet_end,
  output logic                                 was_patched,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [h4df_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [h4df_pkg::CFG_DATA_W-1:0] cfg_data
);

  logic                        q_valid;
  logic [h4df_pkg::BYTE_W-1:0] q_byte;
  logic                        can_load;
  logic                        fire;
  logic                        patch_enable;
  logic [h4df_pkg::BYTE_W-1:0] feature_clear_mask;
  h4df_pkg::result_t           res;
  h4df_pkg::result_t           res_q;

  assign cfg_ready = 1'b1;
  assign fire      = q_valid && can_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      patch_enable       <= 1'b0;
      feature_clear_mask <= h4df_pkg::FEATURE_MASK_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        h4df_pkg::CFG_PATCH_ENABLE: patch_enable       <= cfg_data[0];
        h4df_pkg::CFG_FEATURE_MASK: feature_clear_mask <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  h4df_in_reg u_in_reg (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_byte  (in_byte),
    .take     (fire),
    .q_valid  (q_valid),
    .q_byte   (q_byte)
  );

  h4df_core u_core (
    .clk                (clk),
    .rst                (rst),
    .fire               (fire),
    .b                  (q_byte),
    .patch_enable       (patch_enable),
    .feature_clear_mask (feature_clear_mask),
    .res                (res)
  );

  h4df_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (fire),
    .res       (res),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .can_load  (can_load),
    .res_q     (res_q)
  );

  assign out_byte     = res_q.out_byte;
  assign forwarded    = res_q.forwarded;
  assign packet_start = res_q.packet_start;
  assign packet_end   = res_q.packet_end;
  assign was_patched  = res_q.was_patched;

  a_start_fwd: assert property (@(posedge clk) disable iff (rst)
    out_valid && (packet_start || packet_end) |-> forwarded)
    else $error("packet mark on a dropped word");

  a_patch_body: assert property (@(posedge clk) disable iff (rst)
    out_valid && was_patched |-> forwarded && !packet_start)
    else $error("patch applied outside an event body");

  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled while output free");

endmodule
`default_nettype wire

// ===== hdl/h4df_in_reg.sv =====
`default_nettype none
module h4df_in_reg (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic [h4df_pkg::BYTE_W-1:0] in_byte,
  input  wire logic                      take,
  output logic                           q_valid,
  output logic [h4df_pkg::BYTE_W-1:0]    q_byte
);

  logic load;

  assign load     = !q_valid || take;
  assign in_stall = q_valid && !take;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (load) begin
      q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && in_valid) begin
      q_byte <= in_byte;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/h4df_core.sv =====
`default_nettype none
module h4df_core (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        fire,
  input  wire logic [h4df_pkg::BYTE_W-1:0] b,
  input  wire logic                        patch_enable,
  input  wire logic [h4df_pkg::BYTE_W-1:0] feature_clear_mask,
  output h4df_pkg::result_t                res
);

  logic [h4df_pkg::POS_W-1:0]  byte_position, byte_position_next;
  logic [h4df_pkg::KIND_W-1:0] packet_kind, packet_kind_next;
  logic [h4df_pkg::POS_W-1:0]  pkt_len, pkt_len_next;
  logic [h4df_pkg::BYTE_W-1:0] length_low_byte, length_low_byte_next;
  logic                        fixup_match, fixup_match_next;
  logic [h4df_pkg::POS_W-1:0]  pos_inc;
  logic [15:0]                 len16;
  logic                        known_type;

  assign pos_inc    = byte_position + h4df_pkg::POS_W'(1);
  assign len16      = {b, length_low_byte};
  assign known_type = (b >= h4df_pkg::BYTE_W'(h4df_pkg::KIND_COMMAND)) &&
                      (b <= h4df_pkg::BYTE_W'(h4df_pkg::KIND_ISO));

  always_comb begin
    byte_position_next   = byte_position;
    packet_kind_next     = packet_kind;
    pkt_len_next         = pkt_len;
    length_low_byte_next = length_low_byte;
    fixup_match_next     = fixup_match;
    res.out_byte         = b;
    res.forwarded        = 1'b0;
    res.packet_start     = 1'b0;
    res.packet_end       = 1'b0;
    res.was_patched      = 1'b0;

    if (byte_position == h4df_pkg::POS_TYPE) begin
      if (known_type) begin
        packet_kind_next   = b[h4df_pkg::KIND_W-1:0];
        res.forwarded      = 1'b1;
        res.packet_start   = 1'b1;
        byte_position_next = h4df_pkg::POS_W'(1);
        pkt_len_next       = '0;
        fixup_match_next   = (b == h4df_pkg::BYTE_W'(h4df_pkg::KIND_EVENT));
      end
    end else begin
      res.forwarded = 1'b1;

      case (packet_kind)
        h4df_pkg::KIND_COMMAND, h4df_pkg::KIND_SCO: begin
          if (byte_position == h4df_pkg::POS_LEN_LO)
            pkt_len_next = h4df_pkg::HDR_LEN_CMD_SCO + h4df_pkg::POS_W'(b);
        end
        h4df_pkg::KIND_EVENT: begin
          if (byte_position == h4df_pkg::POS_EVT_LEN)
            pkt_len_next = h4df_pkg::HDR_LEN_EVENT + h4df_pkg::POS_W'(b);
        end
        h4df_pkg::KIND_ACL: begin
          if (byte_position == h4df_pkg::POS_LEN_LO)
            length_low_byte_next = b;
          else if (byte_position == h4df_pkg::POS_LEN_HI)
            pkt_len_next = h4df_pkg::HDR_LEN_ACL_ISO + h4df_pkg::POS_W'(len16);
        end
        h4df_pkg::KIND_ISO: begin
          if (byte_position == h4df_pkg::POS_LEN_LO)
            length_low_byte_next = b;
          else if (byte_position == h4df_pkg::POS_LEN_HI)
            pkt_len_next = h4df_pkg::HDR_LEN_ACL_ISO +
                           h4df_pkg::POS_W'(len16 & h4df_pkg::ISO_LEN_MASK);
        end
        default: begin
        end
      endcase

      // Command Complete for Read Local Extended Features, status ok, page 2
      if (packet_kind == h4df_pkg::KIND_EVENT) begin
        if (byte_position == h4df_pkg::POS_EVT_CODE) begin
          if (b != h4df_pkg::EVT_CMD_COMPLETE) fixup_match_next = 1'b0;
        end else if (byte_position == h4df_pkg::POS_LEN_HI) begin
          if (b != h4df_pkg::OPCODE_EXT_FEAT[7:0]) fixup_match_next = 1'b0;
        end else if (byte_position == h4df_pkg::POS_OPCODE_HI) begin
          if (b != h4df_pkg::OPCODE_EXT_FEAT[15:8]) fixup_match_next = 1'b0;
        end else if (byte_position == h4df_pkg::POS_STATUS) begin
          if (b != h4df_pkg::STATUS_OK) fixup_match_next = 1'b0;
        end else if (byte_position == h4df_pkg::POS_PAGE) begin
          if (b != h4df_pkg::EXT_FEAT_PAGE) fixup_match_next = 1'b0;
        end else if (byte_position == h4df_pkg::POS_FEAT0 && fixup_match && patch_enable) begin
          res.out_byte    = b & ~feature_clear_mask;
          res.was_patched = 1'b1;
        end
      end

      if (pkt_len_next != '0 && pos_inc == pkt_len_next) begin
        res.packet_end     = 1'b1;
        byte_position_next = h4df_pkg::POS_TYPE;
        packet_kind_next   = h4df_pkg::KIND_NONE;
        pkt_len_next       = '0;
        fixup_match_next   = 1'b0;
      end else begin
        byte_position_next = pos_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position   <= h4df_pkg::POS_TYPE;
      packet_kind     <= h4df_pkg::KIND_NONE;
      pkt_len         <= '0;
      length_low_byte <= '0;
      fixup_match     <= 1'b0;
    end else if (fire) begin
      byte_position   <= byte_position_next;
      packet_kind     <= packet_kind_next;
      pkt_len         <= pkt_len_next;
      length_low_byte <= length_low_byte_next;
      fixup_match     <= fixup_match_next;
    end
  end

  // between packets the kind, length and match state of the last one may not linger
  a_idle_clean: assert property (@(posedge clk) disable iff (rst)
    byte_position == h4df_pkg::POS_TYPE |->
      packet_kind == h4df_pkg::KIND_NONE && pkt_len == '0 && !fixup_match)
    else $error("stale packet state while waiting for type byte");

  a_match_event: assert property (@(posedge clk) disable iff (rst)
    fixup_match |-> packet_kind == h4df_pkg::KIND_EVENT)
    else $error("fix-up match outside an event packet");

  a_len_ahead: assert property (@(posedge clk) disable iff (rst)
    pkt_len != '0 |-> pkt_len > byte_position)
    else $error("position ran past packet length");

endmodule
`default_nettype wire

// ===== hdl/h4df_out_reg.sv =====
`default_nettype none
module h4df_out_reg (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              load,
  input  wire h4df_pkg::result_t res,
  input  wire logic              out_stall,
  output logic                   out_valid,
  output logic                   can_load,
  output h4df_pkg::result_t      res_q
);

  assign can_load = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (can_load) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (can_load && load) begin
      res_q <= res;
    end
  end

endmodule
`default_nettype wire
